// File: design/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared constants, register indexes and types of the 3x3 image filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int CSUM_W     = 18;
  localparam int RES_W      = 20;
  localparam int LB_AW      = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_BOTTOM = 3'd4;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;
  localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] top;
    logic signed [COEF_W-1:0] mid;
    logic signed [COEF_W-1:0] bot;
  } coef_col_t;

endpackage

// File: design/c3f_pix_if.sv
// ----------------------------------------------------------------------------
// c3f_pix_if
// Pixel request channel: raster-order samples with a frame start flag.
// ----------------------------------------------------------------------------
interface c3f_pix_if;
  import c3f_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);

endinterface

// File: design/c3f_res_if.sv
// ----------------------------------------------------------------------------
// c3f_res_if
// Result request channel: filtered value and window center position.
// ----------------------------------------------------------------------------
interface c3f_res_if;
  import c3f_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] filtered_value;
  logic [COORD_W-1:0]      center_row;
  logic [COORD_W-1:0]      center_column;
  logic                    frame_last;

  modport source (output valid, filtered_value, center_row, center_column, frame_last,
                  input ready);
  modport sink   (input valid, filtered_value, center_row, center_column, frame_last,
                  output ready);

endinterface

// File: design/c3f_ram.sv
// ----------------------------------------------------------------------------
// c3f_ram
// Generic single write port, single read port RAM with registered read.
// Read returns the old contents when read and write hit the same address.
// ----------------------------------------------------------------------------
module c3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/c3f_cell.sv
// ----------------------------------------------------------------------------
// c3f_cell
// One window column: holds three pixels, hands them to its left neighbor
// on each shift and registers the column's weighted sum.
// ----------------------------------------------------------------------------
module c3f_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  c3f_pkg::pix_col_t                col_i,
  input  c3f_pkg::coef_col_t               coef_i,
  input  logic                             sum_en_i,
  output c3f_pkg::pix_col_t                col_o,
  output logic signed [c3f_pkg::CSUM_W-1:0] sum_o
);
  import c3f_pkg::*;

  pix_col_t                 col_q;
  logic signed [CSUM_W-1:0] p_top, p_mid, p_bot;
  logic signed [CSUM_W-1:0] sum_d, sum_q;

  assign p_top = CSUM_W'($signed({1'b0, col_q.top})) * CSUM_W'(coef_i.top);
  assign p_mid = CSUM_W'($signed({1'b0, col_q.mid})) * CSUM_W'(coef_i.mid);
  assign p_bot = CSUM_W'($signed({1'b0, col_q.bot})) * CSUM_W'(coef_i.bot);
  assign sum_d = p_top + p_mid + p_bot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

// File: design/conv3x3_image_filter_top.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter_top
// Streaming 3x3 correlation over raster-order pixels; one result per
// interior window center, tagged with its row and column.
// Pipeline: a pixel completing its window passes the line buffer read, the
// window cells, the column sums and then the output register as a result.
// Throughput: one pixel per cycle while the result channel is not stalled,
// bounded by the one read and one write per cycle of each line buffer RAM.
// Reset: position counters and window cleared, registers to defaults; line
// buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  c3f_pix_if.sink                           pix_i,
  c3f_res_if.source                         res_o
);
  import c3f_pkg::*;

  localparam int NCELL = 3;

  // configuration
  logic [DIM_W-1:0]      img_w_q, img_h_q;
  logic [CFG_DATA_W-1:0] kern_top_q, kern_mid_q, kern_bot_q;
  logic [DIM_W-1:0]      w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= WIDTH_RST;
      img_h_q    <= HEIGHT_RST;
      kern_top_q <= '0;
      kern_mid_q <= '0;
      kern_bot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMG_WIDTH:   img_w_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMG_HEIGHT:  img_h_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_KERN_TOP:    kern_top_q <= cfg_wdata_i;
        CFG_KERN_MIDDLE: kern_mid_q <= cfg_wdata_i;
        CFG_KERN_BOTTOM: kern_bot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (img_w_q < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (img_w_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = img_w_q;
    end
    priority if (img_h_q < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (img_h_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = img_h_q;
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, res_valid_q;
  logic emit3_q;
  logic out_free, adv1, adv2, adv3, accept;

  assign out_free = !res_valid_q || res_o.ready;
  assign adv3     = !v3_q || !emit3_q || out_free;
  assign adv2     = !v2_q || adv3;
  assign adv1     = !v1_q || adv2;
  assign accept   = pix_i.valid && adv1;

  assign pix_i.ready = adv1;

  // position counters
  logic [COORD_W-1:0] row_q, col_q;
  logic [COORD_W-1:0] r0, c0;
  logic [DIM_W-1:0]   c_inc, r_inc;
  logic [COORD_W-1:0] r_next, c_next;
  logic               emit0, last0;

  always_comb begin
    r0 = (pix_i.frame_start || ({1'b0, row_q} >= h_eff)) ? '0 : row_q;
    c0 = (pix_i.frame_start || ({1'b0, col_q} >= w_eff)) ? '0 : col_q;
    c_inc = {1'b0, c0} + DIM_W'(1);
    r_inc = {1'b0, r0} + DIM_W'(1);
    if (c_inc >= w_eff) begin
      c_next = '0;
      r_next = (r_inc >= h_eff) ? '0 : r_inc[COORD_W-1:0];
    end else begin
      c_next = c_inc[COORD_W-1:0];
      r_next = r0;
    end
    emit0 = (r0 >= COORD_W'(2)) && (c0 >= COORD_W'(2));
    last0 = ({1'b0, r0} == h_eff - DIM_W'(1)) && ({1'b0, c0} == w_eff - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= r_next;
      col_q <= c_next;
    end
  end

  // stage 1: line buffer read data, write back, forward on same address
  logic [PIX_W-1:0]   pix1_q;
  logic [LB_AW-1:0]   addr1_q;
  logic               emit1_q, last1_q;
  logic [COORD_W-1:0] crow1_q, ccol1_q;
  logic               fwd1_q;
  logic [PIX_W-1:0]   fwd_pix1_q, fwd_mid1_q;
  logic [PIX_W-1:0]   lb_mid_rd, lb_top_rd;
  logic [PIX_W-1:0]   mid1, top1;
  logic               lb_we;

  assign mid1  = fwd1_q ? fwd_pix1_q : lb_mid_rd;
  assign top1  = fwd1_q ? fwd_mid1_q : lb_top_rd;
  assign lb_we = v1_q && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q     <= pix_i.pixel_value;
      addr1_q    <= c0[LB_AW-1:0];
      emit1_q    <= emit0;
      last1_q    <= last0;
      crow1_q    <= r0 - COORD_W'(1);
      ccol1_q    <= c0 - COORD_W'(1);
      fwd1_q     <= v1_q && (addr1_q == c0[LB_AW-1:0]);
      fwd_pix1_q <= pix1_q;
      fwd_mid1_q <= mid1;
    end
  end

  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_mid (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (addr1_q),
    .wdata_i (pix1_q),
    .re_i    (accept),
    .raddr_i (c0[LB_AW-1:0]),
    .rdata_o (lb_mid_rd)
  );

  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_top (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (addr1_q),
    .wdata_i (mid1),
    .re_i    (accept),
    .raddr_i (c0[LB_AW-1:0]),
    .rdata_o (lb_top_rd)
  );

  // stage 2: window cells, stage 3: column sums
  logic               emit2_q, last2_q;
  logic [COORD_W-1:0] crow2_q, ccol2_q;
  logic               last3_q;
  logic [COORD_W-1:0] crow3_q, ccol3_q;
  pix_col_t           new_col;
  pix_col_t           cell_col [NCELL];
  logic signed [CSUM_W-1:0] cell_sum [NCELL];

  assign new_col = '{top: top1, mid: mid1, bot: pix1_q};

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    pix_col_t  col_in;
    coef_col_t coef;

    if (j == NCELL - 1) begin : g_head
      assign col_in = new_col;
    end else begin : g_link
      assign col_in = cell_col[j+1];
    end

    assign coef.top = kern_top_q[COEF_W*j +: COEF_W];
    assign coef.mid = kern_mid_q[COEF_W*j +: COEF_W];
    assign coef.bot = kern_bot_q[COEF_W*j +: COEF_W];

    c3f_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (lb_we),
      .col_i    (col_in),
      .coef_i   (coef),
      .sum_en_i (v2_q && adv2),
      .col_o    (cell_col[j]),
      .sum_o    (cell_sum[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      emit2_q <= emit1_q;
      last2_q <= last1_q;
      crow2_q <= crow1_q;
      ccol2_q <= ccol1_q;
    end
    if (v2_q && adv2) begin
      emit3_q <= emit2_q;
      last3_q <= last2_q;
      crow3_q <= crow2_q;
      ccol3_q <= ccol2_q;
    end
  end

  // output register
  logic signed [RES_W-1:0] res_val_q;
  logic [COORD_W-1:0]      res_row_q, res_col_q;
  logic                    res_last_q;
  logic                    res_load;

  assign res_load = out_free && v3_q && emit3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= v3_q && emit3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_val_q  <= RES_W'(cell_sum[0]) + RES_W'(cell_sum[1]) + RES_W'(cell_sum[2]);
      res_row_q  <= crow3_q;
      res_col_q  <= ccol3_q;
      res_last_q <= last3_q;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.filtered_value = res_val_q;
  assign res_o.center_row     = res_row_q;
  assign res_o.center_column  = res_col_q;
  assign res_o.frame_last     = res_last_q;

endmodule
